>>> design/cv_step_sequencer_playback_core_defines.svh
// Assertion macros shared by the checker of the step sequencer playback core.
// Included by the checker file only; depends on nothing else.
`ifndef CV_STEP_SEQUENCER_PLAYBACK_CORE_DEFINES_SVH
`define CV_STEP_SEQUENCER_PLAYBACK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while the synchronous reset is held.
`define CVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the synchronous reset is held.
`define CVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cvs_pkg.sv
// Shared types and constants of the step sequencer playback core.
// Used by the front end, the back end and the top level; depends on nothing.
package cvs_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_CLOCK = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SEQ_LEN    = 3'd0;
    localparam logic [2:0] REG_CLK_DIV    = 3'd1;
    localparam logic [2:0] REG_SLIP_PCT   = 3'd2;
    localparam logic [2:0] REG_DRIFT_PCT  = 3'd3;
    localparam logic [2:0] REG_DRIFT_AMT  = 3'd4;
    localparam logic [2:0] REG_HOLD_OFS   = 3'd5;
    localparam logic [2:0] REG_HOLD_THR   = 3'd6;
    localparam logic [2:0] REG_RESET_MODE = 3'd7;

    localparam logic [6:0]  RST_SEQ_LEN   = 7'd8;
    localparam logic [9:0]  RST_CLK_DIV   = 10'd1;
    localparam logic [9:0]  DIV_COUNT_MAX = 10'h3FF;
    localparam logic [11:0] CV_MAX        = 12'd4095;

    typedef enum logic [1:0] {
        K_CLOCK,
        K_RESET,
        K_WRITE,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  slip;
        logic [6:0]  chance;
        logic [9:0]  offset;
        logic        mute;
        logic [5:0]  widx;
        logic [11:0] wval;
    } t_item;

    typedef struct packed {
        logic [6:0]  seq_len;
        logic [9:0]  clk_div;
        logic [6:0]  slip_pct;
        logic [6:0]  drift_pct;
        logic [8:0]  drift_amt;
        logic [6:0]  hold_ofs;
        logic [11:0] hold_thr;
        logic        reset_mode;
    } t_cfg;

    typedef struct packed {
        logic        cv_valid;
        logic [11:0] cv_value;
        logic        transpose_clock;
        logic        transpose_reset;
        logic [5:0]  current_step;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RST_RD,
        S_CLK,
        S_MOD,
        S_GATE,
        S_OUT,
        S_COMMIT
    } t_state;

endpackage

>>> design/cvs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the step value and step drift stores; depends on nothing.
module cvs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/cvs_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on cvs_pkg.
module cvs_front #(
    parameter int MAX_STEPS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [cvs_pkg::IN_DATA_W-1:0] i_data,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output cvs_pkg::t_item                o_q_item
);
    import cvs_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QW     = $clog2(QDEPTH);

    t_item          r_q [QDEPTH];
    logic [QW-1:0]  r_wr;
    logic [QW-1:0]  r_rd;
    logic [QW:0]    r_cnt;
    t_item          n_item;
    logic           push;
    logic           widx_ok;

    assign o_ready   = (r_cnt != (QW + 1)'(QDEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd];

    // A write beyond the store becomes a no-op here and never reaches the store.
    assign widx_ok = ({26'd0, i_data[30:25]} < 32'(MAX_STEPS));

    always_comb begin
        n_item.slip   = i_data[6:0];
        n_item.chance = i_data[13:7];
        n_item.offset = i_data[23:14];
        n_item.mute   = i_data[24];
        n_item.widx   = i_data[30:25];
        n_item.wval   = i_data[42:31];
        unique case (i_operation)
            OP_CLOCK: n_item.kind = K_CLOCK;
            OP_RESET: n_item.kind = K_RESET;
            OP_WRITE: n_item.kind = widx_ok ? K_WRITE : K_NOP;
            default:  n_item.kind = K_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= (r_rd == QW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> design/cvs_modrem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Used by the back end for the hold look-ahead index; depends on nothing.
module cvs_modrem #(
    parameter int DW = 8,
    parameter int LW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [LW-1:0] i_divisor,
    output logic          o_busy,
    output logic [LW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [LW-1:0] r_div;
    logic [LW-1:0] r_rem;
    logic [LW:0]   trial;
    logic [LW:0]   diff;
    logic [LW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DW-1]};
        diff  = trial - {1'b0, r_div};
        n_rem = (trial >= {1'b0, r_div}) ? diff[LW-1:0] : trial[LW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

>>> design/cvs_back.sv
// Back end: executes queued items against the step stores and registers the result.
// Depends on cvs_pkg, cvs_ram and cvs_modrem.
module cvs_back #(
    parameter int MAX_STEPS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cvs_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  cvs_pkg::t_item   i_q_item,
    output logic             o_valid,
    input  logic             i_ready,
    output cvs_pkg::t_result o_result
);
    import cvs_pkg::*;

    localparam int AW = $clog2(MAX_STEPS);
    localparam int LW = ($clog2(MAX_STEPS + 1) > 7) ? $clog2(MAX_STEPS + 1) : 7;
    localparam int DW = ((AW > 7) ? AW : 7) + 1;

    t_state                r_state;
    t_state                n_state;
    t_item                 r_item;
    logic [AW-1:0]         r_pos;
    logic [9:0]            r_div_cnt;
    logic                  r_pending;
    logic [MAX_STEPS-1:0]  r_vvld;
    logic [MAX_STEPS-1:0]  r_dvld;
    logic                  r_vrd_ok;
    logic                  r_drd_ok;
    logic [AW-1:0]         r_pos_new;
    logic                  r_tclk;
    logic                  r_act;
    logic                  r_drift_on;
    logic                  r_pend_hit;
    logic signed [15:0]    r_drift;
    logic [11:0]           r_cv;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  v_we;
    logic [AW-1:0]         v_waddr;
    logic                  v_re;
    logic [AW-1:0]         v_raddr;
    logic [11:0]           v_rdata;
    logic                  d_we;
    logic                  d_re;
    logic [AW-1:0]         d_raddr;
    logic [15:0]           d_rdata;

    logic                  mod_start;
    logic                  mod_busy;
    logic [LW-1:0]         mod_rem;
    logic [DW-1:0]         mod_dividend;

    logic [LW-1:0]         seq_ext;
    logic [LW-1:0]         eff_len;
    logic [9:0]            div_inc;
    logic                  act;
    logic                  advance;
    logic [LW-1:0]         pos_inc;
    logic [LW-1:0]         pos_step;
    logic [LW-1:0]         pos_fix;
    logic                  wrap;
    logic                  drift_on;
    logic [11:0]           val_eff;
    logic signed [15:0]    drift_eff;
    logic signed [17:0]    drift_sum;
    logic signed [15:0]    drift_sat;
    logic signed [17:0]    cv_sum;
    logic [11:0]           cv_clamp;
    logic                  gate_hit;
    logic                  out_free;
    logic                  commit;
    t_result               res;

    cvs_ram #(.WIDTH(12), .DEPTH(MAX_STEPS)) u_values (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (r_item.wval),
        .i_re    (v_re),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    cvs_ram #(.WIDTH(16), .DEPTH(MAX_STEPS)) u_drift (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (r_pos_new),
        .i_wdata (r_drift),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    cvs_modrem #(.DW(DW), .LW(LW)) u_modrem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (eff_len),
        .o_busy     (mod_busy),
        .o_rem      (mod_rem)
    );

    // Step arithmetic for a clock pulse that reaches the division count.
    always_comb begin
        seq_ext = LW'(i_cfg.seq_len);
        if (seq_ext == '0) begin
            eff_len = LW'(1);
        end else if (seq_ext > LW'(MAX_STEPS)) begin
            eff_len = LW'(MAX_STEPS);
        end else begin
            eff_len = seq_ext;
        end

        div_inc = (r_div_cnt < DIV_COUNT_MAX) ? r_div_cnt + 10'd1 : r_div_cnt;
        act     = (div_inc >= i_cfg.clk_div);
        advance = (i_cfg.slip_pct == '0) || (r_item.slip > i_cfg.slip_pct);

        pos_inc = LW'(r_pos) + LW'(1);
        wrap    = 1'b0;
        if (advance) begin
            if (pos_inc >= eff_len) begin
                pos_step = '0;
                wrap     = 1'b1;
            end else begin
                pos_step = pos_inc;
            end
        end else begin
            pos_step = LW'(r_pos);
        end
        // A shortened sequence can leave the position past its end.
        pos_fix  = (pos_step >= eff_len) ? '0 : pos_step;
        drift_on = advance && (i_cfg.drift_pct != '0) && (r_item.chance < i_cfg.drift_pct);

        mod_dividend = DW'(AW'(pos_fix)) + DW'(i_cfg.hold_ofs);
    end

    // Store reads: an entry unwritten since reset (drift: or restart) reads as zero.
    always_comb begin
        val_eff   = r_vrd_ok ? v_rdata : '0;
        drift_eff = r_drd_ok ? $signed(d_rdata) : 16'sd0;
        drift_sum = $signed({{2{drift_eff[15]}}, drift_eff})
                  + $signed({8'd0, r_item.offset})
                  - $signed({9'd0, i_cfg.drift_amt});
        if (drift_sum > 18'sd32767) begin
            drift_sat = 16'sh7FFF;
        end else if (drift_sum < -18'sd32768) begin
            drift_sat = 16'sh8000;
        end else begin
            drift_sat = drift_sum[15:0];
        end
        cv_sum = $signed({6'd0, val_eff}) + $signed({{2{r_drift[15]}}, r_drift});
        if (cv_sum < 18'sd0) begin
            cv_clamp = '0;
        end else if (cv_sum > $signed({6'd0, CV_MAX})) begin
            cv_clamp = CV_MAX;
        end else begin
            cv_clamp = cv_sum[11:0];
        end
        gate_hit = (i_cfg.reset_mode == 1'b0) && (val_eff > i_cfg.hold_thr);
    end

    always_comb begin
        res              = '0;
        res.current_step = 6'(r_pos);
        case (r_item.kind)
            K_CLOCK: begin
                if (r_act) begin
                    res.cv_valid        = r_pend_hit && !r_item.mute;
                    res.cv_value        = res.cv_valid ? r_cv : '0;
                    res.transpose_clock = r_tclk;
                    res.current_step    = 6'(r_pos_new);
                end
            end
            K_RESET: begin
                if (i_cfg.reset_mode == 1'b0) begin
                    res.cv_valid        = 1'b1;
                    res.cv_value        = val_eff;
                    res.transpose_reset = 1'b1;
                    res.current_step    = '0;
                end
            end
            default: ;
        endcase
    end

    assign out_free = !r_out_valid || i_ready;
    assign v_we     = commit && (r_item.kind == K_WRITE);
    assign v_waddr  = AW'(r_item.widx);
    assign d_we     = commit && (r_item.kind == K_CLOCK) && r_act && r_drift_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        v_re      = 1'b0;
        v_raddr   = '0;
        d_re      = 1'b0;
        d_raddr   = '0;
        mod_start = 1'b0;
        commit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.kind)
                        K_CLOCK: n_state = S_CLK;
                        K_RESET: n_state = i_cfg.reset_mode ? S_COMMIT : S_RST_RD;
                        default: n_state = S_COMMIT;
                    endcase
                end
            end
            S_RST_RD: begin
                v_re    = 1'b1;
                n_state = S_COMMIT;
            end
            S_CLK: begin
                if (act) begin
                    d_re      = 1'b1;
                    d_raddr   = AW'(pos_fix);
                    mod_start = 1'b1;
                    n_state   = S_MOD;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_MOD: begin
                if (!mod_busy) begin
                    v_re    = 1'b1;
                    v_raddr = AW'(mod_rem);
                    n_state = S_GATE;
                end
            end
            S_GATE: begin
                v_re    = 1'b1;
                v_raddr = r_pos_new;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (v_re) begin
            r_vrd_ok <= r_vvld[v_raddr];
        end
        if (d_re) begin
            r_drd_ok <= r_dvld[d_raddr];
        end
        if (r_state == S_CLK) begin
            r_act      <= act;
            r_pos_new  <= AW'(pos_fix);
            r_tclk     <= wrap;
            r_drift_on <= drift_on;
        end
        if ((r_state == S_MOD) && !mod_busy) begin
            r_drift <= r_drift_on ? drift_sat : drift_eff;
        end
        if (r_state == S_GATE) begin
            r_pend_hit <= r_pending || gate_hit;
        end
        if (r_state == S_OUT) begin
            r_cv <= cv_clamp;
        end
        if (commit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_div_cnt   <= '0;
            r_pending   <= 1'b0;
            r_vvld      <= '0;
            r_dvld      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit) begin
                case (r_item.kind)
                    K_CLOCK: begin
                        r_div_cnt <= r_act ? '0 : div_inc;
                        if (r_act) begin
                            // Any pending sample is consumed by a counted pulse.
                            r_pos     <= r_pos_new;
                            r_pending <= 1'b0;
                            if (r_drift_on) begin
                                r_dvld[r_pos_new] <= 1'b1;
                            end
                        end
                    end
                    K_RESET: begin
                        if (i_cfg.reset_mode == 1'b0) begin
                            r_pos  <= '0;
                            r_dvld <= '0;
                        end else begin
                            r_pending <= 1'b1;
                        end
                    end
                    K_WRITE: r_vvld[v_waddr] <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> design/cv_step_sequencer_playback_core.sv
// Step sequencer playback core: top level with the configuration registers, built from
// cvs_front, cvs_back (with cvs_ram and cvs_modrem) and cvs_pkg. Every input item
// (clock pulse, reset pulse or step value write) gives exactly one result item. The front
// end queues up to two items, so input is taken while the back end works and while a
// result waits in the output register. A counted clock pulse takes longest in the back
// end, as it waits for the bit-serial remainder unit that finds the hold look-ahead
// step. The user must write the registers only while the core is idle; the block itself
// does not enforce it.
module cv_step_sequencer_playback_core #(
    parameter int MAX_STEPS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [6:0] slip_draw, [13:7] drift_chance_draw, [23:14] drift_offset_draw,
    // [24] mute_output, [30:25] write_index, [42:31] write_value, [47:43] zero
    input  logic [cvs_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [11:0] cv_value, [12] transpose_clock, [13] transpose_reset,
    // [19:14] current_step, [23:20] zero
    output logic [cvs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] cv_valid
    output logic                           o_m_axis_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [4:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import cvs_pkg::*;

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    q_valid;
    logic    q_pop;
    t_item   q_item;
    t_result result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seq_len    <= RST_SEQ_LEN;
            r_cfg.clk_div    <= RST_CLK_DIV;
            r_cfg.slip_pct   <= '0;
            r_cfg.drift_pct  <= '0;
            r_cfg.drift_amt  <= '0;
            r_cfg.hold_ofs   <= '0;
            r_cfg.hold_thr   <= '0;
            r_cfg.reset_mode <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_SEQ_LEN:    r_cfg.seq_len    <= pwdata[6:0];
                REG_CLK_DIV:    r_cfg.clk_div    <= pwdata[9:0];
                REG_SLIP_PCT:   r_cfg.slip_pct   <= pwdata[6:0];
                REG_DRIFT_PCT:  r_cfg.drift_pct  <= pwdata[6:0];
                REG_DRIFT_AMT:  r_cfg.drift_amt  <= pwdata[8:0];
                REG_HOLD_OFS:   r_cfg.hold_ofs   <= pwdata[6:0];
                REG_HOLD_THR:   r_cfg.hold_thr   <= pwdata[11:0];
                REG_RESET_MODE: r_cfg.reset_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SEQ_LEN:    prdata = {25'd0, r_cfg.seq_len};
            REG_CLK_DIV:    prdata = {22'd0, r_cfg.clk_div};
            REG_SLIP_PCT:   prdata = {25'd0, r_cfg.slip_pct};
            REG_DRIFT_PCT:  prdata = {25'd0, r_cfg.drift_pct};
            REG_DRIFT_AMT:  prdata = {23'd0, r_cfg.drift_amt};
            REG_HOLD_OFS:   prdata = {25'd0, r_cfg.hold_ofs};
            REG_HOLD_THR:   prdata = {20'd0, r_cfg.hold_thr};
            REG_RESET_MODE: prdata = {31'd0, r_cfg.reset_mode};
            default:        prdata = '0;
        endcase
    end

    cvs_front #(.MAX_STEPS(MAX_STEPS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_operation (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_item    (q_item)
    );

    cvs_back #(.MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_item  (q_item),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {4'd0, result.current_step, result.transpose_reset,
                             result.transpose_clock, result.cv_value};
    assign o_m_axis_tuser = result.cv_valid;

endmodule

>>> design/cvs_checker.sv
// Port-level checks on the result stream of the step sequencer playback core,
// bound to the top level. Depends on cv_step_sequencer_playback_core_defines.svh.
`include "cv_step_sequencer_playback_core_defines.svh"

module cvs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // A stalled result item must stay put until it is taken.
    `CVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result item changed while stalled")

    // A restart always drives a value and lands on the first step.
    `CVS_ASSERT_NOW(a_restart_step0, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[13], o_m_axis_tuser && (o_m_axis_tdata[19:14] == 6'd0), "restart without value or off step zero")

    // A wrap lands on the first step and never coincides with a restart.
    `CVS_ASSERT_NOW(a_wrap_step0, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[12], (o_m_axis_tdata[19:14] == 6'd0) && !o_m_axis_tdata[13], "wrap off step zero or with restart")

    // With no value driven, the value field reads zero.
    `CVS_ASSERT_NOW(a_idle_cv_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata[11:0] == 12'd0, "value field not zero without a driven value")

endmodule

bind cv_step_sequencer_playback_core cvs_checker u_cvs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> verif/cv_step_sequencer_playback_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of cv_step_sequencer_playback_core: clock pulses, reset pulses
// and step writes go in over the input stream, and every output item is predicted and compared.
// Depends on cvs_pkg and the core only; reads no files.
module cv_step_sequencer_playback_core_test;
    import cvs_pkg::*;

    localparam int STEPS       = 64;
    localparam int HALF_PERIOD = 5;
    localparam int SETTLE      = 30;
    localparam int QUIET_LIMIT = 3000;
    localparam int PRINT_CAP   = 100;

    class cv_scoreboard;
        t_cfg        cfg;
        int          step_pos;
        int          pulse_count;
        bit          sample_armed;
        logic [11:0] step_value [STEPS];
        int          step_drift [STEPS];
        t_result     cv_due [$];
        int          errors;
        int          seen;

        function new();
            cfg = '0;
            cfg.seq_len = RST_SEQ_LEN;
            cfg.clk_div = RST_CLK_DIV;
            step_pos = 0;
            pulse_count = 0;
            sample_armed = 0;
            errors = 0;
            seen = 0;
            foreach (step_value[i]) begin
                step_value[i] = '0;
                step_drift[i] = 0;
            end
        endfunction

        // Lengths of zero behave as one step, lengths beyond the store as the full store.
        static function int span_of(logic [6:0] len);
            if (len == 0) return 1;
            if (len > STEPS) return STEPS;
            return int'(len);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_SEQ_LEN:    cfg.seq_len    = v[6:0];
                REG_CLK_DIV:    cfg.clk_div    = v[9:0];
                REG_SLIP_PCT:   cfg.slip_pct   = v[6:0];
                REG_DRIFT_PCT:  cfg.drift_pct  = v[6:0];
                REG_DRIFT_AMT:  cfg.drift_amt  = v[8:0];
                REG_HOLD_OFS:   cfg.hold_ofs   = v[6:0];
                REG_HOLD_THR:   cfg.hold_thr   = v[11:0];
                REG_RESET_MODE: cfg.reset_mode = v[0];
                default: ;
            endcase
        endfunction

        // Works out the output item that one accepted input item causes.
        function void play_item(t_item it);
            t_result r;
            int      span;
            int      sum;
            int      look;
            r = '0;
            span = span_of(cfg.seq_len);
            case (it.kind)
                K_WRITE: step_value[it.widx] = it.wval;
                K_RESET: begin
                    if (!cfg.reset_mode) begin
                        step_pos = 0;
                        foreach (step_drift[i]) step_drift[i] = 0;
                        r.transpose_reset = 1'b1;
                        r.cv_valid = 1'b1;
                        r.cv_value = step_value[0];
                    end else begin
                        sample_armed = 1;
                    end
                end
                K_CLOCK: begin
                    if (pulse_count < int'(DIV_COUNT_MAX)) pulse_count++;
                    if (pulse_count >= int'(cfg.clk_div)) begin
                        if (cfg.slip_pct == 0 || it.slip > cfg.slip_pct) begin
                            step_pos++;
                            if (step_pos >= span) begin
                                step_pos = 0;
                                r.transpose_clock = 1'b1;
                            end
                            if (cfg.drift_pct != 0 && it.chance < cfg.drift_pct) begin
                                sum = step_drift[step_pos] + int'(it.offset)
                                    - int'(cfg.drift_amt);
                                if (sum > 32767) sum = 32767;
                                if (sum < -32768) sum = -32768;
                                step_drift[step_pos] = sum;
                            end
                        end
                        // A shortened sequence can leave the position past its end.
                        if (step_pos >= span) step_pos = 0;
                        look = (step_pos + int'(cfg.hold_ofs)) % span;
                        if (!cfg.reset_mode && step_value[look] > cfg.hold_thr)
                            sample_armed = 1;
                        if (sample_armed) begin
                            sum = int'(step_value[step_pos]) + step_drift[step_pos];
                            if (sum < 0) sum = 0;
                            if (sum > int'(CV_MAX)) sum = int'(CV_MAX);
                            if (!it.mute) begin
                                r.cv_valid = 1'b1;
                                r.cv_value = sum[11:0];
                            end
                            sample_armed = 0;
                        end
                        pulse_count = 0;
                    end
                end
                default: ;
            endcase
            r.current_step = step_pos[5:0];
            cv_due.push_back(r);
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            if (errors < PRINT_CAP)
                $display("mismatch on output item %0d, %s: got %0h, expected %0h",
                         seen, field, got, want);
            errors++;
        endtask

        task check_cv(t_result got);
            t_result want;
            seen++;
            if (cv_due.size() == 0) begin
                report("item with nothing outstanding", got, 0);
                return;
            end
            want = cv_due.pop_front();
            if (got.cv_valid !== want.cv_valid)
                report("cv_valid", got.cv_valid, want.cv_valid);
            if (got.cv_value !== want.cv_value)
                report("cv_value", got.cv_value, want.cv_value);
            if (got.transpose_clock !== want.transpose_clock)
                report("transpose_clock", got.transpose_clock, want.transpose_clock);
            if (got.transpose_reset !== want.transpose_reset)
                report("transpose_reset", got.transpose_reset, want.transpose_reset);
            if (got.current_step !== want.current_step)
                report("current_step", got.current_step, want.current_step);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [1:0]            i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [4:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    cv_scoreboard sb = new();
    bit           steady = 1'b0;
    int           quiet = 0;

    cv_step_sequencer_playback_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin : collect
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.cv_valid        = o_m_axis_tuser;
            got.cv_value        = o_m_axis_tdata[11:0];
            got.transpose_clock = o_m_axis_tdata[12];
            got.transpose_reset = o_m_axis_tdata[13];
            got.current_step    = o_m_axis_tdata[19:14];
            sb.check_cv(got);
        end
    end

    // Ends a run that stops moving: no item taken or delivered and no register access.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_item make_item(t_kind kind, logic [6:0] slip, logic [6:0] chance,
                                        logic [9:0] offset, logic mute, logic [5:0] widx,
                                        logic [11:0] wval);
        t_item it;
        it.kind   = kind;
        it.slip   = slip;
        it.chance = chance;
        it.offset = offset;
        it.mute   = mute;
        it.widx   = widx;
        it.wval   = wval;
        return it;
    endfunction

    function automatic t_cfg setting(logic [6:0] len, logic [9:0] div, logic [6:0] slip,
                                     logic [6:0] dpct, logic [8:0] damt, logic [6:0] hofs,
                                     logic [11:0] hthr, logic mode);
        t_cfg c;
        c.seq_len    = len;
        c.clk_div    = div;
        c.slip_pct   = slip;
        c.drift_pct  = dpct;
        c.drift_amt  = damt;
        c.hold_ofs   = hofs;
        c.hold_thr   = hthr;
        c.reset_mode = mode;
        return c;
    endfunction

    function automatic t_cfg random_setting();
        t_cfg c;
        int   pick;
        pick = $urandom_range(9);
        c.seq_len = (pick == 0) ? 7'd1 : (pick == 1) ? 7'd64 :
                    (pick == 2) ? 7'($urandom_range(127)) :
                    (pick < 6) ? 7'($urandom_range(8, 2)) : 7'($urandom_range(64, 1));
        c.clk_div = ($urandom_range(7) == 0) ? 10'd0 : 10'($urandom_range(3, 1));
        c.slip_pct = ($urandom_range(2) == 0) ? 7'd0 : 7'($urandom_range(99, 1));
        pick = $urandom_range(9);
        c.drift_pct = (pick < 3) ? 7'd0 : (pick == 3) ? 7'd100 : 7'($urandom_range(99, 1));
        c.drift_amt = ($urandom_range(9) == 0) ? 9'd511 : 9'($urandom_range(300));
        c.hold_ofs = $urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(8));
        c.hold_thr = 12'($urandom_range(4095));
        c.reset_mode = ($urandom_range(3) == 0);
        return c;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        int    span;
        pick = $urandom_range(99);
        it.kind = (pick < 58) ? K_CLOCK : (pick < 68) ? K_RESET : (pick < 96) ? K_WRITE : K_NOP;
        it.slip = ($urandom_range(19) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(99));
        it.chance = ($urandom_range(19) == 0) ? 7'($urandom_range(127))
                                              : 7'($urandom_range(99));
        if ($urandom_range(19) == 0)
            it.offset = 10'($urandom_range(1023));
        else if (sb.cfg.drift_amt == 0)
            it.offset = '0;
        else
            it.offset = 10'($urandom_range(2 * sb.cfg.drift_amt - 1));
        it.mute = ($urandom_range(4) == 0);
        span = cv_scoreboard::span_of(sb.cfg.seq_len);
        it.widx = $urandom_range(1) ? 6'($urandom_range(span - 1)) : 6'($urandom_range(63));
        pick = $urandom_range(9);
        it.wval = (pick == 0) ? 12'd0 : (pick == 1) ? 12'hFFF : 12'($urandom_range(4095));
        return it;
    endfunction

    task automatic send(t_item it);
        while (!steady && $urandom_range(99) < 13) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {5'd0, it.wval, it.widx, it.mute, it.offset, it.chance, it.slip};
        i_s_axis_tuser  = it.kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.play_item(it);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
    endtask

    // Lets every outstanding item come back, then gives the core time to go idle.
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.cv_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply(t_cfg c);
        drain();
        write_reg(REG_SEQ_LEN, c.seq_len);
        write_reg(REG_CLK_DIV, c.clk_div);
        write_reg(REG_SLIP_PCT, c.slip_pct);
        write_reg(REG_DRIFT_PCT, c.drift_pct);
        write_reg(REG_DRIFT_AMT, c.drift_amt);
        write_reg(REG_HOLD_OFS, c.hold_ofs);
        write_reg(REG_HOLD_THR, c.hold_thr);
        write_reg(REG_RESET_MODE, c.reset_mode);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: eight steps, every pulse counts, gating on any non-zero value.
        send(make_item(K_WRITE, 7'd0, 7'd0, 10'd0, 1'b0, 6'd0, 12'hFFF));
        send(make_item(K_WRITE, 7'd0, 7'd0, 10'd0, 1'b0, 6'd63, 12'h800));
        send(make_item(K_WRITE, 7'd0, 7'd0, 10'd0, 1'b0, 6'd1, 12'd1));
        send(make_item(K_CLOCK, 7'd127, 7'd127, 10'd1023, 1'b0, 6'd0, 12'd0));
        send(make_item(K_CLOCK, 7'd0, 7'd0, 10'd0, 1'b0, 6'd0, 12'd0));
        send(make_item(K_NOP, 7'd127, 7'd127, 10'd1023, 1'b1, 6'd63, 12'hFFF));
        send(make_item(K_WRITE, 7'd0, 7'd0, 10'd0, 1'b0, 6'd3, 12'd7));
        send(make_item(K_CLOCK, 7'd0, 7'd0, 10'd0, 1'b1, 6'd0, 12'd0));
        send(make_item(K_RESET, 7'd0, 7'd0, 10'd0, 1'b0, 6'd0, 12'd0));
        send(make_item(K_WRITE, 7'd0, 7'd0, 10'd0, 1'b0, 6'd7, 12'd100));
        for (int n = 0; n < 9; n++)
            send(make_item(K_CLOCK, 7'd0, 7'd0, 10'd0, 1'b0, 6'd0, 12'd0));

        // One-step loop with drift on every pulse, driven up to its saturation limit and then down again.
        apply(setting(7'd0, 10'd0, 7'd0, 7'd127, 9'd0, 7'd0, 12'd0, 1'b0));
        for (int n = 0; n < 40; n++)
            send(make_item(K_CLOCK, 7'($urandom_range(99)), 7'($urandom_range(99)),
                           10'd1023, 1'b0, 6'd0, 12'd0));
        apply(setting(7'd0, 10'd0, 7'd0, 7'd127, 9'd511, 7'd0, 12'd0, 1'b0));
        for (int n = 0; n < 70; n++)
            send(make_item(K_CLOCK, 7'($urandom_range(99)), 7'($urandom_range(99)),
                           10'd0, 1'b0, 6'd0, 12'd0));

        // Every register at the top of its field.
        apply(setting(7'd127, 10'd1023, 7'd127, 7'd127, 9'd511, 7'd127, 12'hFFF, 1'b1));
        for (int n = 0; n < 20; n++) send(random_item());

        // Sample-and-hold: a reset pulse arms, the next counted pulse plays the step.
        apply(setting(7'd64, 10'd2, 7'd99, 7'd0, 9'd0, 7'd64, 12'd0, 1'b1));
        send(make_item(K_RESET, 7'd0, 7'd0, 10'd0, 1'b0, 6'd0, 12'd0));
        send(make_item(K_CLOCK, 7'd0, 7'd0, 10'd0, 1'b0, 6'd0, 12'd0));
        send(make_item(K_CLOCK, 7'd100, 7'd0, 10'd0, 1'b0, 6'd0, 12'd0));
        send(make_item(K_CLOCK, 7'd100, 7'd0, 10'd0, 1'b0, 6'd0, 12'd0));
        send(make_item(K_RESET, 7'd0, 7'd0, 10'd0, 1'b0, 6'd0, 12'd0));
        send(make_item(K_CLOCK, 7'd100, 7'd0, 10'd0, 1'b1, 6'd0, 12'd0));
        send(make_item(K_CLOCK, 7'd100, 7'd0, 10'd0, 1'b1, 6'd0, 12'd0));

        for (int ph = 0; ph < 8; ph++) begin
            apply(random_setting());
            steady = (ph == 3);
            for (int n = 0; n < 62; n++) send(random_item());
        end
        steady = 1'b0;

        drain();
        if (sb.cv_due.size() != 0) sb.report("items never delivered", sb.cv_due.size(), 0);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> cv_step_sequencer_playback_core.f
+incdir+design
design/cvs_pkg.sv
design/cvs_ram.sv
design/cvs_front.sv
design/cvs_modrem.sv
design/cvs_back.sv
design/cv_step_sequencer_playback_core.sv
design/cvs_checker.sv
verif/cv_step_sequencer_playback_core_test.sv
